// ----- design/decs_pkg.sv -----
`default_nettype none
package decs_pkg;

   localparam int unsigned FIELD_W  = 32;
   localparam int unsigned DENS_W   = 31;
   localparam int unsigned ETA_W    = 16;
   localparam int unsigned FLOOR_W  = 31;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 31;
   localparam int unsigned QUOT_W   = 64;
   localparam int unsigned DIV_W    = 32;
   localparam int unsigned RHS_W    = 47;
   localparam int unsigned PROD_W   = 62;

   localparam logic [CSR_IDX_W-1:0] CSR_ETA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_EN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR = 2'd2;

   // side data that rides along the divider
   typedef struct packed {
      logic signed [FIELD_W-1:0] e;
      logic signed [FIELD_W-1:0] adv;
      logic [RHS_W-1:0]          rhs;
      logic                      emax_pos;
      logic [PROD_W-1:0]         prod;
      logic                      fen;
   } side_type;

endpackage
`default_nettype wire

// ----- design/decs_req_if.sv -----
`default_nettype none
interface decs_req_if
   import decs_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [DENS_W-1:0]         density;
   logic signed [FIELD_W-1:0] mom_x;
   logic signed [FIELD_W-1:0] mom_y;
   logic signed [FIELD_W-1:0] mom_z;
   logic signed [FIELD_W-1:0] total_energy;
   logic signed [FIELD_W-1:0] advected_energy;
   logic signed [FIELD_W-1:0] energy_left;
   logic signed [FIELD_W-1:0] energy_right;
   logic signed [FIELD_W-1:0] energy_below;
   logic signed [FIELD_W-1:0] energy_above;
   logic signed [FIELD_W-1:0] energy_back;
   logic signed [FIELD_W-1:0] energy_front;

   modport source (output valid, density, mom_x, mom_y, mom_z, total_energy,
                   advected_energy, energy_left, energy_right, energy_below, energy_above,
                   energy_back, energy_front, input ready);
   modport sink (input valid, density, mom_x, mom_y, mom_z, total_energy,
                 advected_energy, energy_left, energy_right, energy_below, energy_above,
                 energy_back, energy_front, output ready);
endinterface

interface decs_rsp_if #(parameter int VALUE_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] new_total_energy;
   logic signed [VALUE_WIDTH-1:0] new_internal_energy;
   logic                          used_advected;
   logic                          floor_hit;

   modport source (output valid, new_total_energy, new_internal_energy, used_advected,
                   floor_hit, input ready);
   modport sink (input valid, new_total_energy, new_internal_energy, used_advected,
                 floor_hit, output ready);
endinterface
`default_nettype wire

// ----- design/decs_div.sv -----
`default_nettype none
module decs_div
   import decs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [QUOT_W-1:0] in_num,
   input  wire logic [DIV_W-1:0]  in_den,
   input  wire side_type          in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [QUOT_W-1:0]      out_quot,
   output side_type               out_side
);
   // one restoring step per stage, quotient bits msb first
   localparam int NS = QUOT_W;

   logic              valid_ff [NS];
   logic [DIV_W-1:0]  rem_ff   [NS];
   logic [QUOT_W-1:0] num_ff   [NS];
   logic [QUOT_W-1:0] quo_ff   [NS];
   logic [DIV_W-1:0]  den_ff   [NS];
   side_type          side_ff  [NS];
   logic              adv      [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic              src_valid;
      logic [DIV_W-1:0]  src_rem;
      logic [QUOT_W-1:0] src_num;
      logic [QUOT_W-1:0] src_quo;
      logic [DIV_W-1:0]  src_den;
      side_type          src_side;
      logic [DIV_W:0]    part;
      logic              fits;
      logic [DIV_W:0]    diff;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_num   = in_num;
         assign src_quo   = '0;
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_num   = num_ff[k-1];
         assign src_quo   = quo_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      if (k == NS - 1) begin : g_last
         assign adv[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid
         assign adv[k] = !valid_ff[k] || adv[k+1];
      end

      assign part = {src_rem, src_num[QUOT_W-1]};
      assign fits = part >= {1'b0, src_den};
      assign diff = part - {1'b0, src_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid;
         end
         if (adv[k] && src_valid) begin
            rem_ff[k]  <= fits ? diff[DIV_W-1:0] : part[DIV_W-1:0];
            num_ff[k]  <= {src_num[QUOT_W-2:0], 1'b0};
            quo_ff[k]  <= {src_quo[QUOT_W-2:0], fits};
            den_ff[k]  <= src_den;
            side_ff[k] <= src_side;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NS-1];
   assign out_quot  = quo_ff[NS-1];
   assign out_side  = side_ff[NS-1];
endmodule
`default_nettype wire

// ----- design/dual_energy_cell_sync_unit.sv -----
`default_nettype none
// channel   | role                     | handshake
// req_chan  | cell transaction in      | valid/ready, accepted when both high
// rsp_chan  | energy transaction out   | valid/ready, accepted when both high
// csr_*     | register write           | csr_wr_en, no back-pressure
//
// two front stages (squares, maximum, products), 64 divider stages for the kinetic
// energy (one quotient bit each), then select, floor and output stages; one
// transaction is taken every cycle when nothing stalls
// reset is synchronous and empties every stage; configuration registers return to defaults
// each stage holds while its successor is full and stalled, so bubbles are
// squeezed out and back-pressure on rsp_chan reaches req_chan only when all fill
module dual_energy_cell_sync_unit
   import decs_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   decs_req_if.sink                   req_chan,
   decs_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (VALUE_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
   localparam logic signed [64:0] CL_HI  = (65'sd1 <<< 47) - 65'sd1;
   localparam logic signed [64:0] CL_LO  = -(65'sd1 <<< 47);

   // clamp to 48 bits then scale by 2^16
   function automatic logic signed [63:0] clamp_scale(input logic signed [64:0] v);
      logic signed [64:0] c;
      c = (v > CL_HI) ? CL_HI : ((v < CL_LO) ? CL_LO : v);
      return {c[47:0], 16'h0000};
   endfunction

   function automatic logic [FIELD_W-1:0] mag(input logic signed [FIELD_W-1:0] p);
      return p[FIELD_W-1] ? (~p + 32'd1) : p;
   endfunction

   // ---------------- configuration registers
   logic [ETA_W-1:0]   eta_ff;
   logic               fen_ff;
   logic [FLOOR_W-1:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff   <= 16'd66;
         fen_ff   <= 1'b0;
         floor_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ETA:      eta_ff   <= csr_wdata[ETA_W-1:0];
            CSR_FLOOR_EN: fen_ff   <= csr_wdata[0];
            CSR_FLOOR:    floor_ff <= csr_wdata[FLOOR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage advance chain
   logic adv_a, adv_b, adv_c, adv_d, adv_e;
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic div_in_ready, div_out_valid;

   assign adv_e = !e_valid_ff || rsp_chan.ready;
   assign adv_d = !d_valid_ff || adv_e;
   assign adv_c = !c_valid_ff || adv_d;
   assign adv_b = !b_valid_ff || div_in_ready;
   assign adv_a = !a_valid_ff || adv_b;
   assign req_chan.ready = adv_a;

   // ---------------- stage a: squares, neighbourhood maximum, floor product
   // a square of the most negative momentum needs the full 63 bits
   logic [QUOT_W-2:0]         sq_in [3];
   logic signed [FIELD_W-1:0] max01, max23, max45, max_lo, max_hi, emax_in;
   logic [DENS_W-1:0]         dens_in;

   assign dens_in  = (req_chan.density == '0) ? 31'd1 : req_chan.density;
   assign sq_in[0] = {31'd0, mag(req_chan.mom_x)} * {31'd0, mag(req_chan.mom_x)};
   assign sq_in[1] = {31'd0, mag(req_chan.mom_y)} * {31'd0, mag(req_chan.mom_y)};
   assign sq_in[2] = {31'd0, mag(req_chan.mom_z)} * {31'd0, mag(req_chan.mom_z)};
   assign max01 = (req_chan.energy_left > req_chan.energy_right) ?
                  req_chan.energy_left : req_chan.energy_right;
   assign max23 = (req_chan.energy_below > req_chan.energy_above) ?
                  req_chan.energy_below : req_chan.energy_above;
   assign max45 = (req_chan.energy_back > req_chan.energy_front) ?
                  req_chan.energy_back : req_chan.energy_front;
   assign max_lo = (max01 > max23) ? max01 : max23;
   assign max_hi = (max45 > req_chan.total_energy) ? max45 : req_chan.total_energy;
   assign emax_in = (max_lo > max_hi) ? max_lo : max_hi;

   logic [QUOT_W-2:0]         a_sq_ff [3];
   logic signed [FIELD_W-1:0] a_emax_ff, a_e_ff, a_adv_ff;
   logic [DENS_W-1:0]         a_dens_ff;
   logic [PROD_W-1:0]         a_prod_ff;
   logic                      a_fen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv_a) begin
         a_valid_ff <= req_chan.valid;
      end
      if (adv_a && req_chan.valid) begin
         a_sq_ff   <= sq_in;
         a_emax_ff <= emax_in;
         a_e_ff    <= req_chan.total_energy;
         a_adv_ff  <= req_chan.advected_energy;
         a_dens_ff <= dens_in;
         a_prod_ff <= dens_in * floor_ff;
         a_fen_ff  <= fen_ff;
      end
   end

   // ---------------- stage b: sum of squares, eta times maximum
   logic [QUOT_W-1:0] b_sum_ff;
   logic [DIV_W-1:0]  b_den_ff;
   side_type          b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv_b) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv_b && a_valid_ff) begin
         b_sum_ff <= {1'b0, a_sq_ff[0]} + {1'b0, a_sq_ff[1]} + {1'b0, a_sq_ff[2]};
         b_den_ff <= {a_dens_ff, 1'b0};
         b_side_ff.e        <= a_e_ff;
         b_side_ff.adv      <= a_adv_ff;
         b_side_ff.rhs      <= eta_ff * a_emax_ff[FIELD_W-2:0];
         b_side_ff.emax_pos <= (a_emax_ff > 32'sd0);
         b_side_ff.prod     <= a_prod_ff;
         b_side_ff.fen      <= a_fen_ff;
      end
   end

   // ---------------- kinetic energy divider
   logic [QUOT_W-1:0] div_quot;
   side_type          div_side;

   decs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (div_in_ready),
      .in_num    (b_sum_ff),
      .in_den    (b_den_ff),
      .in_side   (b_side_ff),
      .out_valid (div_out_valid),
      .out_ready (adv_c),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // ---------------- stage c: dual-energy selection
   logic signed [64:0] ge_c;
   logic signed [63:0] lhs_c;
   logic               pick_adv_c;

   assign ge_c  = 65'(div_side.e) - $signed({1'b0, div_quot});
   assign lhs_c = clamp_scale(ge_c);
   assign pick_adv_c = !div_side.emax_pos ||
                       !(lhs_c > $signed({17'd0, div_side.rhs}));

   logic [QUOT_W-1:0]  c_ek_ff;
   logic signed [64:0] c_u_ff;
   logic               c_use_adv_ff;
   logic [PROD_W-1:0]  c_prod_ff;
   logic               c_fen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv_c) begin
         c_valid_ff <= div_out_valid;
      end
      if (adv_c && div_out_valid) begin
         c_ek_ff      <= div_quot;
         c_u_ff       <= pick_adv_c ? 65'(div_side.adv) : ge_c;
         c_use_adv_ff <= pick_adv_c;
         c_prod_ff    <= div_side.prod;
         c_fen_ff     <= div_side.fen;
      end
   end

   // ---------------- stage d: floor and total rebuild
   logic               hit_d;
   logic signed [64:0] u_d;

   assign hit_d = c_fen_ff && (clamp_scale(c_u_ff) < $signed({2'b00, c_prod_ff}));
   assign u_d   = hit_d ? $signed({19'd0, c_prod_ff[PROD_W-1:16]}) : c_u_ff;

   logic signed [65:0] d_total_ff;
   logic signed [65:0] d_u_ff;
   logic               d_use_adv_ff;
   logic               d_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv_d) begin
         d_valid_ff <= c_valid_ff;
      end
      if (adv_d && c_valid_ff) begin
         d_total_ff   <= $signed({2'b00, c_ek_ff}) + 66'(u_d);
         d_u_ff       <= 66'(u_d);
         d_use_adv_ff <= c_use_adv_ff;
         d_hit_ff     <= hit_d;
      end
   end

   // ---------------- stage e: saturation and output register
   function automatic logic [VALUE_WIDTH-1:0] sat(input logic signed [65:0] v);
      logic signed [65:0] c;
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return c[VALUE_WIDTH-1:0];
   endfunction

   logic [VALUE_WIDTH-1:0] e_total_ff, e_u_ff;
   logic                   e_use_adv_ff, e_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv_e) begin
         e_valid_ff <= d_valid_ff;
      end
      if (adv_e && d_valid_ff) begin
         e_total_ff   <= sat(d_total_ff);
         e_u_ff       <= sat(d_u_ff);
         e_use_adv_ff <= d_use_adv_ff;
         e_hit_ff     <= d_hit_ff;
      end
   end

   assign rsp_chan.valid               = e_valid_ff;
   assign rsp_chan.new_total_energy    = e_total_ff;
   assign rsp_chan.new_internal_energy = e_u_ff;
   assign rsp_chan.used_advected       = e_use_adv_ff;
   assign rsp_chan.floor_hit           = e_hit_ff;

   // ---------------- checks
   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !e_valid_ff && !a_valid_ff)
      else $error("pipeline not empty after reset");

   a_nonpos_max_uses_adv: assert property (@(posedge clock) disable iff (reset)
      div_out_valid && !div_side.emax_pos |-> pick_adv_c)
      else $error("non-positive neighbourhood maximum must select advected energy");

   a_floor_nonneg: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && d_hit_ff |-> !d_u_ff[65])
      else $error("floored internal energy negative");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && adv_e |=> e_valid_ff)
      else $error("transaction lost between floor and output stages");

   a_floor_needs_enable: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && !c_fen_ff |-> !hit_d)
      else $error("floor applied while disabled");

endmodule
`default_nettype wire
